### hdl/signed_radix_digit_emitter_defines.svh
// Assertion macros for the signed radix digit emitter RTL.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRDE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRDE_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRDE_ASSERT(label, clk, rst_n, prop, msg)
`define SRDE_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### hdl/srde_pkg.sv
// Types, constants and reciprocal tables of the signed radix digit emitter.
`timescale 1ns / 1ps
package srde_pkg;

  localparam int unsigned ALPHA_SLOTS = 16;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned BUF_DEPTH   = 32;
  localparam int unsigned BUF_AW      = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned RECIP_W     = 33;
  localparam int unsigned PROD_W      = 65;
  localparam int unsigned SHAMT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic conv_done;
    logic last_digit;
  } sts_t;

  // floor(2^(32+l) / b) + 1 with l = ceil(log2 b): exact quotient for any 32-bit dividend.
  function automatic logic [RECIP_W-1:0] recip_mult(input logic [RADIX_W-1:0] base);
    logic [RECIP_W-1:0] m;
    m = '0;
    case (base)
      5'd2:    m = 33'h1_0000_0001;
      5'd3:    m = 33'h1_5555_5556;
      5'd4:    m = 33'h1_0000_0001;
      5'd5:    m = 33'h1_9999_999A;
      5'd6:    m = 33'h1_5555_5556;
      5'd7:    m = 33'h1_2492_4925;
      5'd8:    m = 33'h1_0000_0001;
      5'd9:    m = 33'h1_C71C_71C8;
      5'd10:   m = 33'h1_9999_999A;
      5'd11:   m = 33'h1_745D_1746;
      5'd12:   m = 33'h1_5555_5556;
      5'd13:   m = 33'h1_3B13_B13C;
      5'd14:   m = 33'h1_2492_4925;
      5'd15:   m = 33'h1_1111_1112;
      5'd16:   m = 33'h1_0000_0001;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Right shift that goes with recip_mult: 32 + ceil(log2 b).
  function automatic logic [SHAMT_W-1:0] recip_shift(input logic [RADIX_W-1:0] base);
    logic [SHAMT_W-1:0] s;
    s = 6'd36;
    case (base)
      5'd2:                      s = 6'd33;
      5'd3, 5'd4:                s = 6'd34;
      5'd5, 5'd6, 5'd7, 5'd8:    s = 6'd35;
      default:                   s = 6'd36;
    endcase
    return s;
  endfunction

endpackage

### hdl/srde_ctrl.sv
// Controller state machine of the signed radix digit emitter.
`timescale 1ns / 1ps
module srde_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  srde_pkg::sts_t  sts_i,
  output srde_pkg::cmd_t  cmd_o,
  output logic            busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          // An invalid alphabet swallows the item without any output.
          if (sts_i.alpha_ok) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.conv_done) begin
          state_d = sts_i.neg ? S_SIGN : S_EMIT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.last_digit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

### hdl/srde_datapath.sv
// Datapath: configuration registers, reciprocal divider, digit buffer and output register.
`timescale 1ns / 1ps
module srde_datapath #(
  parameter int unsigned MAX_BASE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srde_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srde_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic signed [srde_pkg::VALUE_W-1:0] value_i,
  input  srde_pkg::cmd_t                      cmd_i,
  output srde_pkg::sts_t                      sts_o,
  output logic                                strobe_o,
  output logic [srde_pkg::CHAR_W-1:0]         character_o,
  output logic                                final_res_o
);

  logic [srde_pkg::RADIX_W-1:0]  radix_q;
  logic [srde_pkg::CFG_W-1:0]    dig_lo_q;
  logic [srde_pkg::CFG_W-1:0]    dig_hi_q;
  logic [srde_pkg::VALUE_W-1:0]  mag_q;
  logic                          neg_q;
  logic [srde_pkg::PROD_W-1:0]   prod_q;
  logic [srde_pkg::DIGIT_W-1:0]  dbuf_q [srde_pkg::BUF_DEPTH];
  logic [srde_pkg::BUF_AW-1:0]   wr_q;
  logic [srde_pkg::BUF_AW-1:0]   rd_q;
  logic [srde_pkg::CHAR_W-1:0]   chr_q;
  logic                          fin_q;
  logic                          stb_q;

  logic [srde_pkg::CHAR_W-1:0]   alph [srde_pkg::ALPHA_SLOTS];
  logic                          alpha_ok;
  logic [srde_pkg::VALUE_W-1:0]  mag_in;
  logic [srde_pkg::RECIP_W-1:0]  recip;
  logic [srde_pkg::PROD_W-1:0]   prod_d;
  logic [srde_pkg::VALUE_W-1:0]  quo;
  logic [srde_pkg::DIGIT_W-1:0]  qb_lo;
  logic [srde_pkg::DIGIT_W-1:0]  rem;
  logic                          conv_done;

  // Alphabet slots as bytes.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      alph[i]     = dig_lo_q[8*i +: 8];
      alph[i + 8] = dig_hi_q[8*i +: 8];
    end
  end

  // Alphabet check over the slots in use: pairwise compares run in parallel.
  always_comb begin
    alpha_ok = (radix_q >= 5'd2) && (radix_q <= srde_pkg::RADIX_W'(MAX_BASE));
    for (int i = 0; i < srde_pkg::ALPHA_SLOTS; i++) begin
      if (5'(i) < radix_q) begin
        if (alph[i] == srde_pkg::CHAR_NUL || alph[i] == srde_pkg::CHAR_PLUS ||
            alph[i] == srde_pkg::CHAR_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < srde_pkg::ALPHA_SLOTS; j++) begin
          if ((5'(j) < radix_q) && (alph[j] == alph[i])) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign mag_in = value_i[srde_pkg::VALUE_W-1] ? (32'd0 - value_i) : value_i;
  assign recip  = srde_pkg::recip_mult(radix_q);
  assign prod_d = {32'd0, recip} * {33'd0, mag_q};
  assign quo    = srde_pkg::VALUE_W'(prod_q >> srde_pkg::recip_shift(radix_q));

  // The remainder is below 16, so only the low nibbles matter.
  assign qb_lo     = quo[3:0] * radix_q[3:0];
  assign rem       = mag_q[3:0] - qb_lo;
  assign conv_done = (quo == '0) || (wr_q == '1);

  assign sts_o.alpha_ok   = alpha_ok;
  assign sts_o.neg        = neg_q;
  assign sts_o.conv_done  = conv_done;
  assign sts_o.last_digit = (rd_q == '0);

  // Configuration, counters and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= '0;
      dig_lo_q <= '0;
      dig_hi_q <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      stb_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srde_pkg::CFG_RADIX:       radix_q  <= cfg_wdata_i[srde_pkg::RADIX_W-1:0];
          srde_pkg::CFG_DIGITS_LOW:  dig_lo_q <= cfg_wdata_i;
          srde_pkg::CFG_DIGITS_HIGH: dig_hi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        wr_q <= '0;
      end else if (cmd_i.div) begin
        rd_q <= wr_q;
        if (!conv_done) begin
          wr_q <= wr_q + 5'd1;
        end
      end else if (cmd_i.emit_digit) begin
        rd_q <= rd_q - 5'd1;
      end
      stb_q <= cmd_i.emit_sign || cmd_i.emit_digit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_in;
      neg_q <= value_i[srde_pkg::VALUE_W-1];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.div) begin
      dbuf_q[wr_q] <= rem;
      mag_q        <= quo;
    end
    if (cmd_i.emit_sign) begin
      chr_q <= srde_pkg::CHAR_MINUS;
      fin_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      chr_q <= alph[dbuf_q[rd_q]];
      fin_q <= (rd_q == '0);
    end
  end

  assign strobe_o    = stb_q;
  assign character_o = chr_q;
  assign final_res_o = fin_q;

endmodule

### hdl/signed_radix_digit_emitter.sv
// Each item gives n digits, 1 to 32, with a leading minus sign for a negative value.
// One item is worked on at a time, and a new one is taken only once the block is idle; the shared
// reciprocal divider alternates a multiply and a divide step per digit and the digit buffer drains one a cycle.
// An item taken with an invalid alphabet gives no character; the next item can follow at once.
// Reset: asynchronous, active low; clears the state machine, counters, strobe and the
// configuration registers, while the payload registers keep whatever they hold.
`timescale 1ns / 1ps
`include "signed_radix_digit_emitter_defines.svh"
module signed_radix_digit_emitter #(
  parameter int unsigned MAX_BASE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [srde_pkg::VALUE_W-1:0] value_i,
  input  logic                                cfg_we_i,
  input  logic [srde_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srde_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                                strobe_o,
  output logic [srde_pkg::CHAR_W-1:0]         character_o,
  output logic                                final_res_o
);

  // The controller and the datapath exchange only a command and a status bundle.
  srde_pkg::cmd_t cmd;
  srde_pkg::sts_t sts;

  // The controller sequences one item at a time: it takes the item, alternates
  // between the reciprocal multiply and the quotient/remainder step for every
  // digit, then emits the minus sign when needed and the digits from the most
  // significant one down.
  srde_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // The datapath holds the alphabet registers and checks the alphabet when an
  // item arrives. Digits come out least significant first, so they are kept in
  // a small buffer and read back in reverse order into the output register.
  srde_datapath #(
    .MAX_BASE (MAX_BASE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .final_res_o (final_res_o)
  );

  // After the final character of an item there is always a quiet cycle, since
  // the next item needs at least a multiply and a divide step first.
  `SRDE_ASSERT(a_quiet_after_final, clk_i, rst_ni, strobe_o && final_res_o |=> !strobe_o, "character strobed directly after a final one")

  // A character that is not the last one means the item is still being worked on.
  `SRDE_ASSERT(a_busy_mid_item, clk_i, rst_ni, strobe_o && !final_res_o |-> busy, "non-final character while the block is idle")

  // Once reset has been seen at an edge, the strobe is low at the next one.
  `SRDE_ASSERT_NORST(a_no_strobe_in_reset, clk_i, !rst_ni |=> !strobe_o, "strobe high during reset")

endmodule
